>>> hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants
// Field widths, command and verdict codes, and the request record that
// travels from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_W     = 16;  // signed Q8.8 coordinate
    localparam int HALF_W      = 15;  // unsigned Q7.8 half size / radius
    localparam int LIM_W       = 17;  // room limit and its negation
    localparam int COUNT_OUT_W = 6;   // reported obstacle count

    // 0.2 m in Q8.8, rounded down
    localparam logic signed [LIM_W-1:0] ROOM_MARGIN = 17'sd51;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        VERDICT_CLEAR    = 2'd0,
        VERDICT_OUTSIDE  = 2'd1,
        VERDICT_OBSTACLE = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_z;
        logic [COORD_W-1:0] max_z;
    } box_t;

    // classified request as held in the queue
    typedef struct packed {
        logic [1:0]         cmd;
        logic               outside;   // query point fails the room check
        box_t               box;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_z;
    } op_t;

endpackage

>>> hw/rtl/aabb_if.sv
// ----------------------------------------------------------------------------
// aabb_if: request and result channels
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface aabb_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic [aabb_pkg::COORD_W-1:0]   box_min_x;
    logic [aabb_pkg::COORD_W-1:0]   box_max_x;
    logic [aabb_pkg::COORD_W-1:0]   box_min_z;
    logic [aabb_pkg::COORD_W-1:0]   box_max_z;
    logic [aabb_pkg::COORD_W-1:0]   point_x;
    logic [aabb_pkg::COORD_W-1:0]   point_z;
    logic [aabb_pkg::HALF_W-1:0]    safety_radius;

    modport source (
        output valid, command, box_min_x, box_max_x, box_min_z, box_max_z,
               point_x, point_z, safety_radius,
        input  ready
    );
    modport sink (
        input  valid, command, box_min_x, box_max_x, box_min_z, box_max_z,
               point_x, point_z, safety_radius,
        output ready
    );
endinterface

interface aabb_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         verdict;
    logic                               table_full;
    logic [aabb_pkg::COUNT_OUT_W-1:0]   obstacle_count;

    modport source (
        output valid, verdict, table_full, obstacle_count,
        input  ready
    );
    modport sink (
        input  valid, verdict, table_full, obstacle_count,
        output ready
    );
endinterface

>>> hw/rtl/aabb_front.sv
// ----------------------------------------------------------------------------
// aabb_front: request intake and classification
// Runs the room limit check on each query and queues the classified
// request (two entries) for the back end.
// ----------------------------------------------------------------------------
module aabb_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [aabb_pkg::HALF_W-1:0] room_half_size,
    aabb_in_if.sink                     in,
    output logic                        op_valid,
    input  logic                        op_ready,
    output aabb_pkg::op_t               op
);
    import aabb_pkg::*;

    op_t                      q_reg [2];
    logic                     wr_ptr_reg, wr_ptr_next;
    logic                     rd_ptr_reg, rd_ptr_next;
    logic [1:0]               q_cnt_reg, q_cnt_next;

    logic signed [LIM_W-1:0]  lim;
    logic signed [LIM_W-1:0]  neg_lim;
    logic signed [LIM_W-1:0]  px;
    logic signed [LIM_W-1:0]  pz;
    logic                     outside;
    logic                     push;
    logic                     pop;
    op_t                      new_op;

    // limit = half size - radius - margin, exact (may go negative)
    assign lim     = $signed({2'b00, room_half_size}) - $signed({2'b00, in.safety_radius})
                     - ROOM_MARGIN;
    assign neg_lim = -lim;
    assign px      = $signed({in.point_x[COORD_W-1], in.point_x});
    assign pz      = $signed({in.point_z[COORD_W-1], in.point_z});
    assign outside = (px > lim) || (px < neg_lim) || (pz > lim) || (pz < neg_lim);

    always_comb
    begin
        new_op.cmd       = in.command;
        new_op.outside   = outside;
        new_op.box.min_x = in.box_min_x;
        new_op.box.max_x = in.box_max_x;
        new_op.box.min_z = in.box_min_z;
        new_op.box.max_z = in.box_max_z;
        new_op.point_x   = in.point_x;
        new_op.point_z   = in.point_z;
    end

    assign in.ready = (q_cnt_reg != 2'd2);
    assign op_valid = (q_cnt_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];
    assign push     = in.valid && in.ready;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_op;
        end
    end

endmodule

>>> hw/rtl/aabb_back.sv
// ----------------------------------------------------------------------------
// aabb_back: obstacle table and execution
// Holds the box memory and count, carries out clear/add, walks the table
// one box per cycle for a query, and drives the result register.
// ----------------------------------------------------------------------------
module aabb_back #(
    parameter int MAX_BOXES = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  aabb_pkg::op_t op,
    aabb_out_if.source    out
);
    import aabb_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pend_reg, pend_next;
    logic [COORD_W-1:0]     px_reg, px_next;
    logic [COORD_W-1:0]     pz_reg, pz_next;
    logic                   out_valid_reg, out_valid_next;
    verdict_t               verdict_reg, verdict_next;
    logic                   full_reg, full_next;
    logic [COUNT_OUT_W-1:0] count_out_reg, count_out_next;

    box_t                   box_table_reg [MAX_BOXES];
    box_t                   rd_data_reg;
    logic                   wr_en;
    logic                   rd_en;
    logic                   hit;
    logic                   take;

    assign op_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out.ready);
    assign take     = op_valid && op_ready;
    assign rd_en    = (state_reg == ST_WALK) && (rd_idx_reg != count_reg);

    // inclusive point-in-box test on the box read last cycle
    assign hit = pend_reg
              && ($signed(px_reg) >= $signed(rd_data_reg.min_x))
              && ($signed(px_reg) <= $signed(rd_data_reg.max_x))
              && ($signed(pz_reg) >= $signed(rd_data_reg.min_z))
              && ($signed(pz_reg) <= $signed(rd_data_reg.max_z));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        full_next      = full_reg;
        count_out_next = count_out_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = VERDICT_CLEAR;
                    full_next      = 1'b0;
                    count_out_next = COUNT_OUT_W'(count_reg);
                    case (op.cmd)
                        CMD_CLEAR:
                        begin
                            count_next     = '0;
                            count_out_next = '0;
                        end
                        CMD_ADD:
                        begin
                            if (count_reg != CNT_MAX)
                            begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + 1'b1;
                                count_out_next = COUNT_OUT_W'(count_reg + 1'b1);
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (op.outside)
                            begin
                                verdict_next = VERDICT_OUTSIDE;
                            end
                            else if (count_reg != '0)
                            begin
                                // hold the result until the walk ends
                                out_valid_next = 1'b0;
                                state_next     = ST_WALK;
                                rd_idx_next    = '0;
                                pend_next      = 1'b0;
                                px_next        = op.point_x;
                                pz_next        = op.point_z;
                            end
                        end
                        default:
                        begin
                            // unused code: no change, count echoed
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                pend_next = rd_en;
                if (hit)
                begin
                    state_next     = ST_IDLE;
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                    verdict_next   = VERDICT_OBSTACLE;
                    full_next      = 1'b0;
                    count_out_next = COUNT_OUT_W'(count_reg);
                end
                else if (pend_reg && !rd_en)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    verdict_next   = VERDICT_CLEAR;
                    full_next      = 1'b0;
                    count_out_next = COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        pz_reg        <= pz_next;
        verdict_reg   <= verdict_next;
        full_reg      <= full_next;
        count_out_reg <= count_out_next;
    end

    // box memory: one write port (append), one registered read port (walk)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_table_reg[count_reg[IDX_W-1:0]] <= op.box;
        end
        if (rd_en)
        begin
            rd_data_reg <= box_table_reg[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign out.valid          = out_valid_reg;
    assign out.verdict        = verdict_reg;
    assign out.table_full     = full_reg;
    assign out.obstacle_count = count_out_reg;

endmodule

>>> hw/rtl/aabb_obstacle_position_check.sv
// ----------------------------------------------------------------------------
// aabb_obstacle_position_check: 2D point-in-box collision checker
// Obstacle table of axis-aligned boxes plus a square room limit check.
// ----------------------------------------------------------------------------
// Keeps up to MAX_BOXES obstacle boxes (signed Q8.8 metres). Each request
// gives exactly one result. Clear empties the table, add appends one box
// (dropped with table_full set when the table is full), query answers
// outside-room if the point lies beyond room_half_size - safety_radius - 0.2 m
// on either axis, otherwise obstacle if it lies inside any stored box (bounds
// inclusive), otherwise clear. Clear, add, unused codes, queries that fail
// the room check and queries on an empty table are answered straight from
// idle in the back end; a query that reaches the table walks the box memory
// through its single read port, one box per cycle, and stops early on the
// first hit. A two-entry queue sits between the intake and the back end, so
// up to two requests are still taken while a query walks or a result waits.
// obstacle_count reports the count modulo 64. The box memory is not cleared
// at reset; only entries below the count are ever read.
// room_half_size resets to 13.0 m and must be written only while idle.
// ----------------------------------------------------------------------------
module aabb_obstacle_position_check #(
    parameter int MAX_BOXES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    aabb_in_if.sink                     in,
    aabb_out_if.source                  out,
    input  logic                        cfg_we,
    input  logic [aabb_pkg::HALF_W-1:0] cfg_wdata
);
    import aabb_pkg::*;

    localparam logic [HALF_W-1:0] HALF_SIZE_RESET = 15'd3328;  // 13.0 m

    logic [HALF_W-1:0] room_half_size_reg, room_half_size_next;
    logic              op_valid;
    logic              op_ready;
    op_t               op;

    // room size register
    assign room_half_size_next = cfg_we ? cfg_wdata : room_half_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_half_size_reg <= HALF_SIZE_RESET;
        end
        else
        begin
            room_half_size_reg <= room_half_size_next;
        end
    end

    // intake: room check and request queue
    aabb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .room_half_size (room_half_size_reg),
        .in             (in),
        .op_valid       (op_valid),
        .op_ready       (op_ready),
        .op             (op)
    );

    // execution: table, walk and result register
    aabb_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .out      (out)
    );

endmodule

>>> tb/aabb_obstacle_position_check_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_obstacle_position_check_checker: obstacle check scoreboard
// Watches the request and result channels and the room register port, keeps
// its own obstacle table and room size, predicts one answer per request and
// compares every returned answer field by field, oldest first.
// ----------------------------------------------------------------------------
module aabb_obstacle_position_check_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    aabb_in_if                          req_ch,
    aabb_out_if                         rsp_ch,
    input  logic                        cfg_we,
    input  logic [aabb_pkg::HALF_W-1:0] cfg_wdata,
    output int                          error_count,
    output int                          pending_count
);
    import aabb_pkg::*;

    typedef struct {
        verdict_t               verdict;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] count;
    } answer_t;

    answer_t           pending_answers[$];
    box_t              obstacle_table[TABLE_DEPTH];
    int                stored_boxes;
    logic [HALF_W-1:0] room_half;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // room check first, then every stored box with inclusive bounds
    function automatic verdict_t classify_point(input logic [COORD_W-1:0] px_raw,
                                                input logic [COORD_W-1:0] pz_raw,
                                                input logic [HALF_W-1:0]  radius);
        int lim;
        int px;
        int pz;
        lim = int'(room_half) - int'(radius) - int'(ROOM_MARGIN);
        px  = int'($signed(px_raw));
        pz  = int'($signed(pz_raw));
        if (px > lim || px < -lim || pz > lim || pz < -lim)
            return VERDICT_OUTSIDE;
        for (int i = 0; i < stored_boxes; i++)
        begin
            if (px >= int'($signed(obstacle_table[i].min_x)) &&
                px <= int'($signed(obstacle_table[i].max_x)) &&
                pz >= int'($signed(obstacle_table[i].min_z)) &&
                pz <= int'($signed(obstacle_table[i].max_z)))
                return VERDICT_OBSTACLE;
        end
        return VERDICT_CLEAR;
    endfunction

    // applies one request to the table and returns the answer it should get
    function automatic answer_t evaluate_request();
        answer_t ans;
        ans.verdict    = VERDICT_CLEAR;
        ans.table_full = 1'b0;
        case (req_ch.command)
            CMD_CLEAR:
                stored_boxes = 0;
            CMD_ADD:
            begin
                if (stored_boxes < TABLE_DEPTH)
                begin
                    obstacle_table[stored_boxes] = '{req_ch.box_min_x, req_ch.box_max_x,
                                                     req_ch.box_min_z, req_ch.box_max_z};
                    stored_boxes++;
                end
                else
                    ans.table_full = 1'b1;
            end
            CMD_QUERY:
                ans.verdict = classify_point(req_ch.point_x, req_ch.point_z,
                                             req_ch.safety_radius);
            default:
                ;
        endcase
        ans.count = COUNT_OUT_W'(stored_boxes);
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        answer_t fresh;
        if (!rst_n)
        begin
            room_half     = HALF_W'(3328);
            stored_boxes  = 0;
            error_count   = 0;
            pending_answers.delete();
        end
        else
        begin
            // result side first: an answer never belongs to a request taken this edge
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("answer arrived with no request outstanding");
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp_ch.verdict !== want.verdict)
                        report_mismatch($sformatf("verdict got %0d want %0d",
                                                  rsp_ch.verdict, want.verdict));
                    if (rsp_ch.table_full !== want.table_full)
                        report_mismatch($sformatf("table_full got %0b want %0b",
                                                  rsp_ch.table_full, want.table_full));
                    if (rsp_ch.obstacle_count !== want.count)
                        report_mismatch($sformatf("obstacle_count got %0d want %0d",
                                                  rsp_ch.obstacle_count, want.count));
                end
            end
            if (cfg_we)
                room_half = cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                fresh = evaluate_request();
                pending_answers.insert(pending_answers.size(), fresh);
            end
        end
        pending_count = pending_answers.size();
    end

endmodule

>>> tb/aabb_obstacle_position_check_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_obstacle_position_check_test: obstacle check testbench top
// Drives clear, add, query and unused requests with random gaps and result
// stalls, moves the room size through several settings between phases, and
// gives the verdict from the scoreboard's mismatch count.
// ----------------------------------------------------------------------------
module aabb_obstacle_position_check_test;
    import aabb_pkg::*;

    localparam int TABLE_DEPTH   = 32;
    localparam int REQUEST_COUNT = 1650;
    localparam int PHASE_COUNT   = 6;
    localparam int MAX_GAP       = 8;
    localparam int ROOM_DEFAULT  = 3328;
    localparam int ROOM_MAX      = 32767;
    localparam int MARGIN_Q88    = 51;
    // the block decodes only three commands; this code must be answered anyway
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [HALF_W-1:0] cfg_wdata;
    int                error_count;
    int                pending_count;

    // set during stretches where neither side idles
    bit   steady;
    // room size the block currently holds, for aiming points at the limits
    int   room_setting;
    // boxes the block should hold, used only to aim queries at edges
    box_t recent_boxes[$];

    aabb_in_if  req_ch();
    aabb_out_if rsp_ch();

    aabb_obstacle_position_check #(
        .MAX_BOXES (TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (req_ch),
        .out       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    aabb_obstacle_position_check_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_ch        (req_ch),
        .rsp_ch        (rsp_ch),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stall before each answer, none in steady stretches
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    function automatic box_t make_box(input int x0, input int x1, input int z0, input int z1);
        box_t b;
        b.min_x = 16'(x0);
        b.max_x = 16'(x1);
        b.min_z = 16'(z0);
        b.max_z = 16'(z1);
        return b;
    endfunction

    // one request: random gap, then hold valid until taken. Called at a falling
    // edge and returns at one; valid stays high so back-to-back needs no toggle.
    task automatic send_request(input logic [1:0]         cmd,
                                input box_t               box,
                                input logic [COORD_W-1:0] px,
                                input logic [COORD_W-1:0] pz,
                                input logic [HALF_W-1:0]  radius);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.command       <= cmd;
        req_ch.box_min_x     <= box.min_x;
        req_ch.box_max_x     <= box.max_x;
        req_ch.box_min_z     <= box.min_z;
        req_ch.box_max_z     <= box.max_z;
        req_ch.point_x       <= px;
        req_ch.point_z       <= pz;
        req_ch.safety_radius <= radius;
        req_ch.valid         <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        // track what the table holds so later queries can hit box edges
        if (cmd == CMD_CLEAR)
            recent_boxes.delete();
        else if (cmd == CMD_ADD && recent_boxes.size() < TABLE_DEPTH)
            recent_boxes.insert(recent_boxes.size(), box);
    endtask

    task automatic query_at(input int x, input int z, input int radius);
        send_request(CMD_QUERY, '0, 16'(x), 16'(z), 15'(radius));
    endtask

    task automatic add_box(input int x0, input int x1, input int z0, input int z1);
        send_request(CMD_ADD, make_box(x0, x1, z0, z1), '0, '0, '0);
    endtask

    // drop valid and wait until every answer is back; the block is then idle
    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_room(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= 15'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        room_setting = value;
    endtask

    // pick a coordinate near a box edge on one axis: just out, on the edge, mid
    function automatic int edge_coord(input logic [COORD_W-1:0] lo,
                                      input logic [COORD_W-1:0] hi);
        int a;
        int b;
        a = int'($signed(lo));
        b = int'($signed(hi));
        case ($urandom_range(0, 4))
            0:       return a - 1;
            1:       return a;
            2:       return b;
            3:       return b + 1;
            default: return (a + b) / 2;
        endcase
    endfunction

    // random request: mostly well-shaped boxes and points inside the room,
    // about one in ten fully random fields as noise
    task automatic send_random_request();
        int         pick;
        int         lim;
        int         cx;
        int         cz;
        int         r;
        int         x;
        int         z;
        box_t       box;
        box_t       target;
        logic [1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            cmd = CMD_CLEAR;
        else if (pick < 5)
            cmd = CMD_UNUSED;
        else if (pick < 45)
            cmd = CMD_ADD;
        else
            cmd = CMD_QUERY;

        if ($urandom_range(0, 9) == 0)
        begin
            box = {$urandom, $urandom};
            send_request(cmd, box, 16'($urandom), 16'($urandom), 15'($urandom));
        end
        else
        begin
            r   = $urandom_range(0, 768);
            lim = room_setting - r - MARGIN_Q88;
            if (lim < 1)
                lim = 1;
            cx = int'($urandom_range(0, 2 * lim)) - lim;
            cz = int'($urandom_range(0, 2 * lim)) - lim;
            box = make_box(cx - int'($urandom_range(0, 1024)), cx + int'($urandom_range(0, 1024)),
                           cz - int'($urandom_range(0, 1024)), cz + int'($urandom_range(0, 1024)));
            // occasional inverted box: never matches but takes a slot
            if ($urandom_range(0, 9) == 0)
                box = make_box(int'($signed(box.max_x)), int'($signed(box.min_x)),
                               int'($signed(box.min_z)), int'($signed(box.max_z)));
            pick = $urandom_range(0, 9);
            if (recent_boxes.size() != 0 && pick < 5)
            begin
                target = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
                x = edge_coord(target.min_x, target.max_x);
                z = edge_coord(target.min_z, target.max_z);
            end
            else if (pick < 8)
            begin
                // room boundary on one axis, exactly on it or one step past
                x = cx;
                z = cz;
                case ($urandom_range(0, 3))
                    0:       x = lim + int'($urandom_range(0, 1));
                    1:       x = -lim - int'($urandom_range(0, 1));
                    2:       z = lim + int'($urandom_range(0, 1));
                    default: z = -lim - int'($urandom_range(0, 1));
                endcase
            end
            else
            begin
                x = cx;
                z = cz;
            end
            send_request(cmd, box, 16'(x), 16'(z), 15'(r));
        end
    endtask

    initial
    begin
        int phase_rooms[PHASE_COUNT];
        int per_phase;
        int hold_at;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_CLEAR;
        req_ch.box_min_x     = '0;
        req_ch.box_max_x     = '0;
        req_ch.box_min_z     = '0;
        req_ch.box_max_z     = '0;
        req_ch.point_x       = '0;
        req_ch.point_z       = '0;
        req_ch.safety_radius = '0;
        steady               = 1'b0;
        room_setting         = ROOM_DEFAULT;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part on the reset room size: limit is 3328 - 51 = 3277
        query_at(0, 0, 0);                      // empty table, clear
        query_at(3277, -3277, 0);               // on the room limit, still clear
        query_at(3278, 0, 0);                   // one step past each side
        query_at(0, -3278, 0);
        query_at(-3278, 0, 0);
        query_at(0, 3278, 0);
        query_at(32767, -32768, 0);             // coordinate extremes
        query_at(0, 0, 32767);                  // negative limit: always outside
        add_box(-256, 256, -256, 256);
        query_at(256, -256, 0);                 // box corner, bounds inclusive
        query_at(257, 0, 0);
        query_at(0, -257, 0);
        add_box(512, 256, 0, 100);              // inverted in x
        query_at(400, 50, 0);
        add_box(-32768, 32767, -32768, 32767);  // box covering everything
        query_at(1000, -1000, 0);
        send_request(CMD_UNUSED, make_box(-1, -1, -1, -1), 16'hffff, 16'hffff, 15'h7fff);
        send_request(CMD_CLEAR, '0, '0, '0, '0);
        query_at(0, 0, 0);

        // room settings per phase, extremes included
        phase_rooms = '{ROOM_MAX, 0, int'($urandom_range(0, ROOM_MAX)), 600, ROOM_DEFAULT,
                        int'($urandom_range(0, ROOM_MAX))};
        per_phase   = REQUEST_COUNT / PHASE_COUNT;

        foreach (phase_rooms[p])
        begin
            // register writes only with nothing in flight
            drain_answers();
            write_room(phase_rooms[p]);
            hold_at = $urandom_range(1, per_phase - 1);
            for (int i = 0; i < per_phase; i++)
            begin
                // toggle into and out of stretches with no idling
                if ($urandom_range(0, 39) == 0)
                    steady = ~steady;
                // sender waits once per phase for the block to empty
                if (i == hold_at)
                    drain_answers();
                send_random_request();
            end
        end

        drain_answers();
        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
